FILE: hdl/mpo_pkg.sv
// Shared constants and helpers for the midpoint pose odometry block.
// Used by midpoint_pose_odometry_top and mpo_checker; no dependencies.
package mpo_pkg;

  // Fraction bits of the sine and cosine values
  localparam int TRIG_FRAC_BITS = 17;
  localparam int SIN_W          = TRIG_FRAC_BITS + 1;

  localparam int POS_W  = 48;
  localparam int ANG_W  = 32;
  localparam int CIRC_W = 20;

  localparam logic [CIRC_W-1:0] CIRC_RESET = 20'd219440;

  // pi in Q30, rounded
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Centidegree landmarks
  localparam int DEN_W = 16;
  localparam logic [DEN_W-1:0] DEG_90   = 16'd9000;
  localparam logic [DEN_W-1:0] DEG_180  = 16'd18000;
  localparam logic [DEN_W-1:0] DEG_270  = 16'd27000;
  localparam logic [DEN_W-1:0] DEG_FULL = 16'd36000;

  // 36000 * 2^17: makes any 33-bit signed mid angle non-negative, same residue
  localparam logic [33:0] MOD_BIAS = 34'd4718592000;

  // Shared multiplier and divider sizes
  localparam int MUL_A_W  = 36;
  localparam int MUL_B_W  = 32;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_W    = 52;
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = DIV_W / DIV_STEP;
  localparam int CNT_W    = $clog2(DIV_CYC);

  // Taylor series runs through the x^15 term
  localparam logic [2:0] LAST_TERM = 3'd7;

  // Divisor (2k)(2k+1) of the k-th series term
  function automatic logic [DEN_W-1:0] term_div(input logic [2:0] k);
    logic [DEN_W-1:0] d;
    case (k)
      3'd1:    d = 16'd6;
      3'd2:    d = 16'd20;
      3'd3:    d = 16'd42;
      3'd4:    d = 16'd72;
      3'd5:    d = 16'd110;
      3'd6:    d = 16'd156;
      3'd7:    d = 16'd210;
      default: d = 16'd6;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/midpoint_pose_odometry_top.sv
// Midpoint-heading dead-reckoning pose tracker: sequencer, shared multiplier
// and shared radix-16 constant divider. Depends on mpo_pkg.
//
// Feed one beat per sensor tick. A baseline beat (op = 1) stores both readings,
// takes the rotation reading as heading and zeroes x and y; its result goes
// through the S_OUT state into the output register. A sample beat (op = 0)
// moves the position by the wheel travel along the heading at the middle of
// the step: the work is one multiplier and one divider reused under a
// sequencer, and the divider, which retires four quotient bits a cycle, makes
// 18 passes per sample (distance, angle reduction, and the angle scaling plus
// seven series terms for each of sine and cosine). The input takes no new beat
// until the current one is finished; a finished result waits in the output
// register without holding up the next input beat, but the next result holds
// until that register drains. Write wheel_circumference (micrometers per turn)
// only while the block is idle.
module midpoint_pose_odometry_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mpo_pkg::CIRC_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [mpo_pkg::ANG_W-1:0]     wheel_angle,
  input  logic signed [mpo_pkg::ANG_W-1:0]     rotation_angle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mpo_pkg::POS_W-1:0]     x_position,
  output logic signed [mpo_pkg::POS_W-1:0]     y_position,
  output logic signed [mpo_pkg::ANG_W-1:0]     heading
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DIST_MUL = 5'd1;
  localparam logic [4:0] S_DIST_DIV = 5'd2;
  localparam logic [4:0] S_DIV      = 5'd3;
  localparam logic [4:0] S_DIST_Q   = 5'd4;
  localparam logic [4:0] S_MID_R    = 5'd5;
  localparam logic [4:0] S_QUAD     = 5'd6;
  localparam logic [4:0] S_X_MUL    = 5'd7;
  localparam logic [4:0] S_X_DIV    = 5'd8;
  localparam logic [4:0] S_X_Q      = 5'd9;
  localparam logic [4:0] S_X2_MUL   = 5'd10;
  localparam logic [4:0] S_X2       = 5'd11;
  localparam logic [4:0] S_T_MUL    = 5'd12;
  localparam logic [4:0] S_T_DIV    = 5'd13;
  localparam logic [4:0] S_T_Q      = 5'd14;
  localparam logic [4:0] S_SIN      = 5'd15;
  localparam logic [4:0] S_P_MUL    = 5'd16;
  localparam logic [4:0] S_P_ADD    = 5'd17;
  localparam logic [4:0] S_OUT      = 5'd18;

  localparam int F = mpo_pkg::TRIG_FRAC_BITS;
  localparam int PW = mpo_pkg::POS_W;

  localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  // Control
  logic [4:0] state;
  logic [4:0] ret_state;

  // Architectural state
  logic [mpo_pkg::CIRC_W-1:0] circ;
  logic [31:0]                last_wheel;
  logic [31:0]                last_rot;
  logic [31:0]                heading_acc;
  logic [PW-1:0]              pos_x;
  logic [PW-1:0]              pos_y;

  // Per-sample working registers
  logic [31:0]                 dw_mag;
  logic                        dist_neg;
  logic [31:0]                 dr;
  logic [35:0]                 dist_mag;
  logic [15:0]                 ang;
  logic                        use_cos;
  logic [13:0]                 rp;
  logic                        sin_neg;
  logic [30:0]                 xq;
  logic [31:0]                 x2;
  logic [30:0]                 term;
  logic signed [33:0]          tsum;
  logic [2:0]                  k;
  logic [mpo_pkg::SIN_W-1:0]   sinv;
  logic [mpo_pkg::MUL_P_W-1:0] prod;

  // Divider
  logic [mpo_pkg::DIV_W-1:0] div_num;
  logic [mpo_pkg::DEN_W-1:0] div_rem;
  logic [mpo_pkg::DEN_W-1:0] div_den;
  logic [mpo_pkg::CNT_W-1:0] div_cnt;

  assign in_ready = (state == S_IDLE);

  // Wheel delta magnitude and sign
  logic [31:0] dw_diff;
  logic [31:0] dw_abs;
  assign dw_diff = wheel_angle - last_wheel;
  assign dw_abs  = dw_diff[31] ? (~dw_diff + 32'd1) : dw_diff;

  // Shared multiplier
  logic [mpo_pkg::MUL_A_W-1:0] mul_a;
  logic [mpo_pkg::MUL_B_W-1:0] mul_b;
  logic [mpo_pkg::MUL_P_W-1:0] prod_next;

  always_comb begin
    case (state)
      S_DIST_MUL: begin
        mul_a = mpo_pkg::MUL_A_W'(dw_mag);
        mul_b = mpo_pkg::MUL_B_W'(circ);
      end
      S_X_MUL: begin
        mul_a = mpo_pkg::MUL_A_W'(rp);
        mul_b = mpo_pkg::PI_Q30;
      end
      S_X2_MUL: begin
        mul_a = mpo_pkg::MUL_A_W'(xq);
        mul_b = mpo_pkg::MUL_B_W'(xq);
      end
      S_T_MUL: begin
        mul_a = mpo_pkg::MUL_A_W'(term);
        mul_b = x2;
      end
      S_P_MUL: begin
        mul_a = dist_mag;
        mul_b = mpo_pkg::MUL_B_W'(sinv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mpo_pkg::MUL_P_W'(mul_a) * mpo_pkg::MUL_P_W'(mul_b);

  // Mid-step angle before reduction, biased non-negative
  logic [32:0] mid_sum;
  logic [33:0] mid_u;
  assign mid_sum = {heading_acc[31], heading_acc} + {dr[31], dr[31], dr[31:1]};
  assign mid_u   = {mid_sum[32], mid_sum} + mpo_pkg::MOD_BIAS;

  // Divider load requests
  logic                      div_load;
  logic [mpo_pkg::DIV_W-1:0] div_load_num;
  logic [mpo_pkg::DEN_W-1:0] div_load_den;
  logic [4:0]                div_load_ret;

  always_comb begin
    div_load     = 1'b1;
    div_load_num = '0;
    div_load_den = mpo_pkg::DEG_FULL;
    div_load_ret = S_IDLE;
    case (state)
      S_DIST_DIV: begin
        div_load_num = prod[mpo_pkg::DIV_W-1:0] + mpo_pkg::DIV_W'(mpo_pkg::DEG_180);
        div_load_den = mpo_pkg::DEG_FULL;
        div_load_ret = S_DIST_Q;
      end
      S_DIST_Q: begin
        div_load_num = mpo_pkg::DIV_W'(mid_u);
        div_load_den = mpo_pkg::DEG_FULL;
        div_load_ret = S_MID_R;
      end
      S_X_DIV: begin
        div_load_num = prod[mpo_pkg::DIV_W-1:0] + mpo_pkg::DIV_W'(mpo_pkg::DEG_90);
        div_load_den = mpo_pkg::DEG_180;
        div_load_ret = S_X_Q;
      end
      S_T_DIV: begin
        div_load_num = mpo_pkg::DIV_W'(prod[62:30]);
        div_load_den = mpo_pkg::term_div(k);
        div_load_ret = S_T_Q;
      end
      default: begin
        div_load = 1'b0;
      end
    endcase
  end

  // Four restoring-division steps per cycle; quotient bits shift in behind the dividend
  logic [mpo_pkg::DIV_W-1:0] div_num_next;
  logic [mpo_pkg::DEN_W-1:0] div_rem_next;
  logic [mpo_pkg::DIV_W-1:0] dn;
  logic [mpo_pkg::DEN_W-1:0] dr_rem;
  logic [mpo_pkg::DEN_W:0]   dt;

  always_comb begin
    dn     = div_num;
    dr_rem = div_rem;
    dt     = '0;
    for (int i = 0; i < mpo_pkg::DIV_STEP; i++) begin
      dt = {dr_rem, dn[mpo_pkg::DIV_W-1]};
      dn = {dn[mpo_pkg::DIV_W-2:0], 1'b0};
      if (dt >= {1'b0, div_den}) begin
        dt    = dt - {1'b0, div_den};
        dn[0] = 1'b1;
      end
      dr_rem = dt[mpo_pkg::DEN_W-1:0];
    end
    div_num_next = dn;
    div_rem_next = dr_rem;
  end

  // Quadrant fold of the sine argument
  logic [16:0] ang_shift;
  logic [15:0] ang_c;
  logic [1:0]  quad;
  logic [15:0] quad_r;
  logic [15:0] rp_wide;

  assign ang_shift = {1'b0, ang} + {1'b0, mpo_pkg::DEG_90};

  always_comb begin
    if (!use_cos) begin
      ang_c = ang;
    end else if (ang_shift >= {1'b0, mpo_pkg::DEG_FULL}) begin
      ang_c = ang_shift[15:0] - mpo_pkg::DEG_FULL;
    end else begin
      ang_c = ang_shift[15:0];
    end
    if (ang_c >= mpo_pkg::DEG_270) begin
      quad   = 2'd3;
      quad_r = ang_c - mpo_pkg::DEG_270;
    end else if (ang_c >= mpo_pkg::DEG_180) begin
      quad   = 2'd2;
      quad_r = ang_c - mpo_pkg::DEG_180;
    end else if (ang_c >= mpo_pkg::DEG_90) begin
      quad   = 2'd1;
      quad_r = ang_c - mpo_pkg::DEG_90;
    end else begin
      quad   = 2'd0;
      quad_r = ang_c;
    end
    rp_wide = quad[0] ? (mpo_pkg::DEG_90 - quad_r) : quad_r;
  end

  // Clamp the series sum and round Q30 down to the trig format
  logic [33:0]               sum_pos;
  logic [33:0]               sum_rnd;
  logic [mpo_pkg::SIN_W-1:0] sin_next;
  assign sum_pos  = tsum[33] ? 34'd0 : tsum;
  assign sum_rnd  = sum_pos + (34'd1 << (29 - F));
  assign sin_next = sum_rnd[30:30-F];

  // Round the displacement, apply sign, saturating add
  logic [mpo_pkg::MUL_P_W:0] p_rnd;
  logic [36:0]               p_mag;
  logic [PW:0]               d_ext;
  logic [PW-1:0]             pos_base;
  logic [PW:0]               pos_sum;
  logic [PW-1:0]             pos_sat;

  assign p_rnd    = {1'b0, prod} + ((mpo_pkg::MUL_P_W + 1)'(1) << (F - 1));
  assign p_mag    = p_rnd[F+36:F];
  assign d_ext    = (dist_neg ^ sin_neg) ? (~(PW + 1)'(p_mag) + (PW + 1)'(1))
                                         : (PW + 1)'(p_mag);
  assign pos_base = use_cos ? pos_y : pos_x;
  assign pos_sum  = {pos_base[PW-1], pos_base} + d_ext;

  always_comb begin
    if (pos_sum[PW] != pos_sum[PW-1]) begin
      pos_sat = pos_sum[PW] ? POS_MIN : POS_MAX;
    end else begin
      pos_sat = pos_sum[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret_state   <= S_IDLE;
      out_valid   <= 1'b0;
      circ        <= mpo_pkg::CIRC_RESET;
      last_wheel  <= '0;
      last_rot    <= '0;
      heading_acc <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
    end else begin
      if (cfg_wr_en) begin
        circ <= cfg_wr_data;
      end
      // drop the taken beat unless a new result replaces it this cycle
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      if (div_load) begin
        div_num   <= div_load_num;
        div_den   <= div_load_den;
        div_rem   <= '0;
        div_cnt   <= mpo_pkg::CNT_W'(mpo_pkg::DIV_CYC - 1);
        ret_state <= div_load_ret;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_wheel <= wheel_angle;
            last_rot   <= rotation_angle;
            if (op) begin
              heading_acc <= rotation_angle;
              pos_x       <= '0;
              pos_y       <= '0;
              state       <= S_OUT;
            end else begin
              dw_mag   <= dw_abs;
              dist_neg <= dw_diff[31];
              dr       <= rotation_angle - last_rot;
              state    <= S_DIST_MUL;
            end
          end
        end
        S_DIST_MUL: begin
          prod  <= prod_next;
          state <= S_DIST_DIV;
        end
        S_DIST_DIV: begin
          state <= S_DIV;
        end
        S_DIV: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          if (div_cnt == '0) begin
            state <= ret_state;
          end else begin
            div_cnt <= div_cnt - mpo_pkg::CNT_W'(1);
          end
        end
        S_DIST_Q: begin
          dist_mag    <= div_num[35:0];
          heading_acc <= heading_acc + dr;
          state       <= S_DIV;
        end
        S_MID_R: begin
          ang     <= div_rem;
          use_cos <= 1'b0;
          state   <= S_QUAD;
        end
        S_QUAD: begin
          rp      <= rp_wide[13:0];
          sin_neg <= quad[1];
          state   <= S_X_MUL;
        end
        S_X_MUL: begin
          prod  <= prod_next;
          state <= S_X_DIV;
        end
        S_X_DIV: begin
          state <= S_DIV;
        end
        S_X_Q: begin
          xq    <= div_num[30:0];
          state <= S_X2_MUL;
        end
        S_X2_MUL: begin
          prod  <= prod_next;
          state <= S_X2;
        end
        S_X2: begin
          x2    <= prod[61:30];
          term  <= xq;
          tsum  <= 34'(xq);
          k     <= 3'd1;
          state <= S_T_MUL;
        end
        S_T_MUL: begin
          prod  <= prod_next;
          state <= S_T_DIV;
        end
        S_T_DIV: begin
          state <= S_DIV;
        end
        S_T_Q: begin
          term <= div_num[30:0];
          // odd terms subtract, even terms add
          if (k[0]) begin
            tsum <= tsum - 34'(div_num[30:0]);
          end else begin
            tsum <= tsum + 34'(div_num[30:0]);
          end
          if (k == mpo_pkg::LAST_TERM) begin
            state <= S_SIN;
          end else begin
            k     <= k + 3'd1;
            state <= S_T_MUL;
          end
        end
        S_SIN: begin
          sinv  <= sin_next;
          state <= S_P_MUL;
        end
        S_P_MUL: begin
          prod  <= prod_next;
          state <= S_P_ADD;
        end
        S_P_ADD: begin
          if (use_cos) begin
            pos_y <= pos_sat;
            state <= S_OUT;
          end else begin
            pos_x   <= pos_sat;
            use_cos <= 1'b1;
            state   <= S_QUAD;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            x_position <= pos_x;
            y_position <= pos_y;
            heading    <= heading_acc;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/mpo_checker.sv
// Port-level assertions for midpoint_pose_odometry_top, attached by bind.
// Depends on mpo_pkg.
module mpo_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             op,
  input logic signed [mpo_pkg::ANG_W-1:0] rotation_angle,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [mpo_pkg::POS_W-1:0] x_position,
  input logic signed [mpo_pkg::POS_W-1:0] y_position,
  input logic signed [mpo_pkg::ANG_W-1:0] heading
);

  // A beat in flight blocks the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a beat was taken");

  // A new result only appears at the end of busy work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in work");

  // Baseline beat into an empty output gives a zero pose and the raw heading
  a_baseline_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op && !out_valid |=> ##1
      (out_valid && x_position == '0 && y_position == '0 &&
       heading == $past(rotation_angle, 2)))
    else $error("baseline result wrong or late");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      (out_valid && $stable(x_position) && $stable(y_position) && $stable(heading)))
    else $error("stalled result changed");

endmodule

bind midpoint_pose_odometry_top mpo_checker u_mpo_checker (.*);
